// File: src/osd_pkg.sv
// ----------------------------------------------------------------------------
// osd_pkg
// Shared types, register indexes and glyph mode table of the OSD character
// generator.
// ----------------------------------------------------------------------------
package osd_pkg;

  // Input word: font load or character render request.
  typedef struct packed {
    logic        func;
    logic [13:0] font_addr;
    logic [7:0]  font_byte;
    logic [7:0]  char_code;
  } osd_in_t;

  // Output word: one glyph row.
  typedef struct packed {
    logic [17:0] pixel_offset;
    logic [23:0] row_mask;
    logic [15:0] pixel_colour;
    logic        last_row;
  } osd_out_t;

  // Configuration register values.
  typedef struct packed {
    logic [1:0]  glyph_mode;
    logic [12:0] line_stride;
    logic [15:0] ink_colour;
  } osd_cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_wr;
    logic pos_clr;
    logic start;
    logic issue;
    logic emit;
    logic pos_adv;
  } osd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_load;
    logic is_end;
    logic full;
    logic byte_last;
    logic row_last;
    logic out_free;
  } osd_stat_t;

  // Per-mode glyph geometry.
  typedef struct packed {
    logic [5:0] rows;
    logic [1:0] bpr;
    logic [7:0] glyph_bytes;
    logic [2:0] step;
    logic [3:0] pitch;
    logic [7:0] limit;
    logic [7:0] second_mask;
  } osd_mode_t;

  localparam logic [1:0] REG_GLYPH_MODE  = 2'd0;
  localparam logic [1:0] REG_LINE_STRIDE = 2'd1;
  localparam logic [1:0] REG_INK_COLOUR  = 2'd2;

  localparam logic [1:0] MODE_8X16  = 2'd0;
  localparam logic [1:0] MODE_12X24 = 2'd1;
  localparam logic [1:0] MODE_16X32 = 2'd2;
  localparam logic [1:0] MODE_24X48 = 2'd3;

  localparam logic [12:0] STRIDE_RESET = 13'd720;
  localparam int          MAX_STRIDE   = 4096;
  localparam logic [12:0] STRIDE_CAP   = 13'(MAX_STRIDE > 8191 ? 8191 : MAX_STRIDE);

  localparam logic [7:0] CHAR_FIRST = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7F;
  localparam logic [7:0] CHAR_SUBST = 8'h3F;

  function automatic osd_mode_t mode_info(input logic [1:0] mode);
    osd_mode_t m;
    case (mode)
      MODE_8X16:  m = '{6'd16, 2'd1, 8'd16,  3'd1, 4'd10, 8'd64,       8'hFF};
      MODE_12X24: m = '{6'd24, 2'd2, 8'd48,  3'd2, 4'd7,  8'(120 + 20), 8'hF0};
      MODE_16X32: m = '{6'd32, 2'd2, 8'd64,  3'd3, 4'd7,  8'(120 + 20), 8'hFF};
      default:    m = '{6'd48, 2'd3, 8'd144, 3'd4, 4'd7,  8'd96,       8'hFF};
    endcase
    return m;
  endfunction

endpackage

// File: src/osd_ram.sv
// ----------------------------------------------------------------------------
// osd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module osd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/osd_regs.sv
// ----------------------------------------------------------------------------
// osd_regs
// APB register file: glyph mode, line stride and ink colour.
// ----------------------------------------------------------------------------
module osd_regs import osd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output osd_cfg_t    cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_mode  <= MODE_8X16;
      cfg.line_stride <= STRIDE_RESET;
      cfg.ink_colour  <= 16'd0;
    end else if (wr) begin
      case (idx)
        REG_GLYPH_MODE:  cfg.glyph_mode  <= pwdata[1:0];
        REG_LINE_STRIDE: cfg.line_stride <= pwdata[12:0];
        REG_INK_COLOUR:  cfg.ink_colour  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GLYPH_MODE:  prdata = {30'd0, cfg.glyph_mode};
      REG_LINE_STRIDE: prdata = {19'd0, cfg.line_stride};
      REG_INK_COLOUR:  prdata = {16'd0, cfg.ink_colour};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// File: src/osd_ctrl.sv
// ----------------------------------------------------------------------------
// osd_ctrl
// Sequencer: takes a word, then walks the glyph rows byte by byte.
// ----------------------------------------------------------------------------
module osd_ctrl import osd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  osd_stat_t stat,
  output osd_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_CAP   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;
  logic       render;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign render   = accept & ~stat.is_load & ~stat.is_end;

  always_comb begin
    cmd.load_wr = accept & stat.is_load;
    cmd.pos_clr = accept & ~stat.is_load & stat.is_end;
    cmd.start   = render & ~stat.full;
    cmd.issue   = (state == S_ISSUE);
    cmd.emit    = (state == S_EMIT) & stat.out_free;
    cmd.pos_adv = (state == S_EMIT) & stat.out_free & stat.row_last;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (cmd.start) state_next = S_ISSUE;
      S_ISSUE: if (stat.byte_last) state_next = S_CAP;
      // last byte lands in the mask at the end of this cycle
      S_CAP:   state_next = S_EMIT;
      S_EMIT: begin
        if (stat.out_free) begin
          state_next = stat.row_last ? S_IDLE : S_ISSUE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/osd_dp.sv
// ----------------------------------------------------------------------------
// osd_dp
// Datapath: font memory, glyph address and offset counters, row mask
// assembly and the output register.
// ----------------------------------------------------------------------------
module osd_dp import osd_pkg::*; #(
  parameter int FONT_BYTES = 16384
) (
  input  logic      clk,
  input  logic      rst,
  input  osd_cfg_t  cfg,
  input  osd_in_t   in_data,
  input  osd_cmd_t  cmd,
  output osd_stat_t stat,
  output logic      out_valid,
  input  logic      out_ready,
  output osd_out_t  out_data
);

  localparam int AW = (FONT_BYTES > 1) ? $clog2(FONT_BYTES) : 1;

  osd_mode_t   mi;
  logic [7:0]  pos;
  logic [13:0] row_addr;
  logic [17:0] offset;
  logic [5:0]  row;
  logic [1:0]  k;
  logic [23:0] mask;
  logic        cap_q;
  logic [1:0]  cap_idx;
  logic        oob_q;

  logic [7:0]  code_sub;
  logic [6:0]  code_idx;
  logic [14:0] glyph_base;
  logic [12:0] stride_eff;
  logic [17:0] start_offset;
  logic [13:0] rd_addr;
  logic [16:0] rd_ext;
  logic [16:0] wr_ext;
  logic        rd_in;
  logic        wr_in;
  logic [7:0]  rdata;
  logic [7:0]  byte_val;

  assign mi = mode_info(cfg.glyph_mode);

  assign stat.is_load   = ~in_data.func;
  assign stat.is_end    = (in_data.char_code == 8'd0);
  assign stat.full      = (pos >= mi.limit);
  assign stat.byte_last = (k == mi.bpr - 2'd1);
  assign stat.row_last  = (row == mi.rows - 6'd1);
  assign stat.out_free  = ~out_valid | out_ready;

  // Substitute '?' for anything outside 0x20..0x7F.
  assign code_sub = (in_data.char_code < CHAR_FIRST || in_data.char_code > CHAR_LAST) ?
                    CHAR_SUBST : in_data.char_code;
  assign code_idx   = 7'(code_sub - CHAR_FIRST);
  assign glyph_base = 15'(code_idx) * 15'(mi.glyph_bytes);

  assign stride_eff   = (cfg.line_stride > STRIDE_CAP) ? STRIDE_CAP : cfg.line_stride;
  assign start_offset = 18'(pos) * 18'(mi.pitch) + 18'd2 + 18'({stride_eff, 1'b0});

  assign rd_addr = row_addr + 14'(k);
  assign rd_ext  = {3'd0, rd_addr};
  assign wr_ext  = {3'd0, in_data.font_addr};
  assign rd_in   = (32'(rd_ext) < FONT_BYTES);
  assign wr_in   = (32'(wr_ext) < FONT_BYTES);

  osd_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_font (
    .clk   (clk),
    .we    (cmd.load_wr & wr_in),
    .waddr (wr_ext[AW-1:0]),
    .wdata (in_data.font_byte),
    .re    (cmd.issue & rd_in),
    .raddr (rd_ext[AW-1:0]),
    .rdata (rdata)
  );

  // Bytes beyond the store read as zero.
  assign byte_val = oob_q ? 8'd0 : rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 8'd0;
      cap_q     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cap_q     <= cmd.issue;
      out_valid <= cmd.emit | (out_valid & ~out_ready);
      if (cmd.pos_clr) begin
        pos <= 8'd0;
      end else if (cmd.pos_adv) begin
        pos <= pos + 8'(mi.step);
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_idx <= k;
    oob_q   <= ~rd_in;
    if (cmd.start) begin
      row_addr <= glyph_base[13:0];
      offset   <= start_offset;
      row      <= 6'd0;
      k        <= 2'd0;
      mask     <= 24'd0;
    end else begin
      if (cmd.issue) begin
        k <= stat.byte_last ? 2'd0 : k + 2'd1;
      end
      if (cap_q) begin
        case (cap_idx)
          2'd0:    mask[23:16] <= byte_val;
          2'd1:    mask[15:8]  <= byte_val & mi.second_mask;
          2'd2:    mask[7:0]   <= byte_val;
          default: ;
        endcase
      end
      if (cmd.emit) begin
        row_addr <= row_addr + 14'(mi.bpr);
        offset   <= offset + 18'(stride_eff);
        row      <= row + 6'd1;
        mask     <= 24'd0;
      end
    end
    if (cmd.emit) begin
      out_data.pixel_offset <= offset;
      out_data.row_mask     <= mask;
      out_data.pixel_colour <= cfg.ink_colour;
      out_data.last_row     <= stat.row_last;
    end
  end

endmodule

// File: src/osd_glyph_row_renderer_core.sv
// ----------------------------------------------------------------------------
// osd_glyph_row_renderer_core
// On-screen-display character generator with a byte-loadable font memory.
// ----------------------------------------------------------------------------
// A load word writes one font byte. A render word emits one
// output word per glyph row (pixel offset in the RGB1555 frame, 24-bit mask
// with bit 23 leftmost, ink colour, last-row flag); code 0 resets the text
// position and emits nothing; a character past the mode's limit is taken
// but emits nothing. The font memory has one read port and each row fetches
// its bytes one per cycle, followed by a capture state and an emit state that
// waits while the output side stalls. Input is taken only between characters;
// a finished row waits in the output register.
// The font memory has no reset; read only bytes that have been loaded.
module osd_glyph_row_renderer_core import osd_pkg::*; #(
  parameter int FONT_BYTES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  osd_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output osd_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  osd_cfg_t  cfg;
  osd_cmd_t  cmd;
  osd_stat_t stat;

  osd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  osd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  osd_dp #(
    .FONT_BYTES (FONT_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: src/osd_checker.sv
// ----------------------------------------------------------------------------
// osd_checker
// Port-level checks for the OSD character generator, bound to the top level.
// ----------------------------------------------------------------------------
module osd_checker import osd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input osd_in_t     in_data,
  input logic        out_valid,
  input logic        out_ready,
  input osd_out_t    out_data,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // hold the output word while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // a font load never occupies the sequencer
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.func |=> in_ready)
    else $error("ready dropped after a font load");

  // a character in flight blocks new input
  a_mid_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_row |-> !in_ready)
    else $error("input taken in the middle of a character");

  a_ink_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[3:2] == REG_INK_COLOUR
    |=> paddr[3:2] != REG_INK_COLOUR || prdata[15:0] == $past(pwdata[15:0]))
    else $error("ink colour readback mismatch");

endmodule

bind osd_glyph_row_renderer_core osd_checker u_osd_checker (.*);
